/* rtl/mp2_pkg.sv */
// mp2_pkg: shared types and fixed widths of the 2x2 max pool with argmax
// no dependencies
`default_nettype none
package mp2_pkg;

  localparam int CFG_W      = 11;
  localparam int ROW_W      = 10;
  localparam int OFFSET_W   = 20;
  localparam int VALUE_W    = 16;
  localparam int MAX_HEIGHT = 1024;

  localparam logic REG_PLANE_WIDTH  = 1'b0;
  localparam logic REG_PLANE_HEIGHT = 1'b1;

  typedef struct packed {
    logic active;
    logic odd_row;
    logic odd_col;
    logic last;
  } mp2_flags_t;

endpackage
`default_nettype wire

/* rtl/mp2_line_store.sv */
// mp2_line_store: line store of top-row pair maxima and their offsets
// one write and one registered read per cycle, write-to-read bypass; uses mp2_pkg
`default_nettype none
module mp2_line_store
  import mp2_pkg::*;
#(
  parameter int DEPTH  = 512,
  parameter int SLOT_W = 9,
  parameter int DATA_W = 36
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [SLOT_W-1:0] rd_slot,
  input  wire logic              wr_en,
  input  wire logic [SLOT_W-1:0] wr_slot,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic      [DATA_W-1:0] rd_data_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_slot == rd_slot)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_slot];
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/mp2_scan.sv */
// mp2_scan: plane registers, raster position counters and the input register
// uses mp2_pkg
`default_nettype none
module mp2_scan
  import mp2_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int SLOT_W      = 9
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          s1_go,
  output logic                               s1_valid_r,
  output mp2_flags_t                         s1_flags_r,
  output logic signed [SAMPLE_BITS-1:0]      s1_sample_r,
  output logic [OFFSET_W-1:0]                s1_offset_r,
  output logic [SLOT_W-1:0]                  s1_slot_r,
  output logic                               rd_en,
  output logic [SLOT_W-1:0]                  rd_slot
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = $clog2(MAX_WIDTH + 1);

  logic [CFG_W-1:0]    width_r;
  logic [CFG_W-1:0]    height_r;
  logic [CW-1:0]       col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [LW-1:0]       w_eff, w_even;
  logic [CFG_W-1:0]    h_eff, h_even;
  logic                accept;
  logic                col_wrap, row_wrap;
  mp2_flags_t          flags;

  always_comb begin
    if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else if (width_r < CFG_W'(2)) begin
      w_eff = LW'(2);
    end else begin
      w_eff = LW'(width_r);
    end
    if (height_r > CFG_W'(MAX_HEIGHT)) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else if (height_r < CFG_W'(2)) begin
      h_eff = CFG_W'(2);
    end else begin
      h_eff = height_r;
    end
  end

  assign w_even = {w_eff[LW-1:1], 1'b0};
  assign h_even = {h_eff[CFG_W-1:1], 1'b0};

  assign flags.active  = (LW'(col_r) < w_even) && (CFG_W'(row_r) < h_even);
  assign flags.odd_row = row_r[0];
  assign flags.odd_col = col_r[0];
  assign flags.last    = (LW'(col_r) == w_even - LW'(1)) &&
                         (CFG_W'(row_r) == h_even - CFG_W'(1));

  assign accept   = in_valid && in_ready;
  assign in_ready = !s1_valid_r || s1_go;
  assign rd_en    = accept;
  assign rd_slot  = SLOT_W'(col_r >> 1);

  assign col_wrap = (LW'(col_r) + LW'(1)) == w_eff;
  assign row_wrap = (CFG_W'(row_r) + CFG_W'(1)) == h_eff;

  always_comb begin
    col_nxt    = col_r + CW'(1);
    row_nxt    = row_r;
    offset_nxt = offset_r + OFFSET_W'(1);
    if (col_wrap) begin
      col_nxt = '0;
      if (row_wrap) begin
        row_nxt    = '0;
        offset_nxt = '0;
      end else begin
        row_nxt = row_r + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(2);
      height_r <= CFG_W'(2);
      col_r    <= '0;
      row_r    <= '0;
      offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLANE_WIDTH:  width_r  <= cfg_wdata;
        REG_PLANE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
      col_r    <= '0;
      row_r    <= '0;
      offset_r <= '0;
    end else if (accept) begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      offset_r <= offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags_r  <= flags;
      s1_sample_r <= in_sample;
      s1_offset_r <= offset_r;
      s1_slot_r   <= rd_slot;
    end
  end

endmodule
`default_nettype wire

/* rtl/mp2_reduce.sv */
// mp2_reduce: window compare, running pair winner and the result register
// uses mp2_pkg; reads the line store data registered alongside the input item
`default_nettype none
module mp2_reduce
  import mp2_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int SLOT_W      = 9
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               s1_valid,
  input  wire mp2_flags_t                         s1_flags,
  input  wire logic signed [SAMPLE_BITS-1:0]      s1_sample,
  input  wire logic [OFFSET_W-1:0]                s1_offset,
  input  wire logic [SLOT_W-1:0]                  s1_slot,
  input  wire logic [SAMPLE_BITS+OFFSET_W-1:0]    rd_data,
  output logic                                    s1_go,
  output logic                                    wr_en,
  output logic [SLOT_W-1:0]                       wr_slot,
  output logic [SAMPLE_BITS+OFFSET_W-1:0]         wr_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [VALUE_W-1:0]               out_max_value,
  output logic [OFFSET_W-1:0]                     out_max_offset,
  output logic                                    out_plane_last
);

  logic signed [SAMPLE_BITS-1:0] pair_val_r, base_val, win_val;
  logic [OFFSET_W-1:0]           pair_off_r, base_off, win_off;
  logic                          out_valid_r;
  logic                          s1_emit, take, from_line;

  assign from_line = s1_flags.odd_row && !s1_flags.odd_col;
  assign base_val  = from_line ? $signed(rd_data[SAMPLE_BITS+OFFSET_W-1:OFFSET_W])
                               : pair_val_r;
  assign base_off  = from_line ? rd_data[OFFSET_W-1:0] : pair_off_r;
  assign take      = !(s1_flags.odd_row || s1_flags.odd_col) || (s1_sample > base_val);
  assign win_val   = take ? s1_sample : base_val;
  assign win_off   = take ? s1_offset : base_off;

  assign s1_emit = s1_valid && s1_flags.active && s1_flags.odd_row && s1_flags.odd_col;
  assign s1_go   = s1_valid && (!s1_emit || !out_valid_r || out_ready);

  assign wr_en   = s1_go && s1_flags.active && !s1_flags.odd_row && s1_flags.odd_col;
  assign wr_slot = s1_slot;
  assign wr_data = {win_val, win_off};

  always_ff @(posedge clk) begin
    if (s1_go && s1_flags.active) begin
      pair_val_r <= win_val;
      pair_off_r <= win_off;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      out_max_value  <= VALUE_W'(unsigned'(win_val));
      out_max_offset <= win_off;
      out_plane_last <= s1_flags.last;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result register not empty after reset");
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("unaccepted result dropped");
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_emit && out_valid_r && !out_ready |-> !s1_go)
    else $error("window result advanced over a stalled result");
  a_no_write_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !s1_emit)
    else $error("line store written by a bottom row item");
`endif

endmodule
`default_nettype wire

/* rtl/max_pool_2x2_argmax.sv */
// max_pool_2x2_argmax: 2x2 stride-2 max pooling with argmax over raster-order planes
// uses mp2_pkg, mp2_scan, mp2_line_store, mp2_reduce
//
// Usage:
//   in_valid/in_ready carry one signed sample per item, raster order, planes back to back.
//   out_valid/out_ready carry one result per 2x2 window on its bottom-right sample:
//   the window maximum, its flat offset row*width+col, and plane_last on the
//   final window of a plane. Ties keep the earlier sample (TL, TR, BL, BR).
//   cfg_we/cfg_index/cfg_wdata write plane_width (0) or plane_height (1); any
//   write restarts the plane at row 0, column 0. Write only while idle.
//   An odd last column or row is consumed and produces nothing.
// Timing:
//   one item per cycle sustained while results are taken; a bottom-right sample
//   passes the input register, then the result register. The input register and the
//   result register are separate, so items that make no result keep flowing
//   while a result waits; a bottom-right item stalls only behind an unaccepted result.
//   The line store is one memory with a registered read issued at accept time.
// Reset:
//   synchronous rst_n clears counters and valid flags and sets both plane
//   registers to 2; the line store needs no clearing pass.
`default_nettype none
module max_pool_2x2_argmax
  import mp2_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [VALUE_W-1:0]          out_max_value,
  output logic [OFFSET_W-1:0]                out_max_offset,
  output logic                               out_plane_last
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int SLOT_W     = $clog2(LINE_DEPTH);
  localparam int DATA_W     = SAMPLE_BITS + OFFSET_W;

  logic                          s1_go, s1_valid, rd_en, wr_en;
  mp2_flags_t                    s1_flags;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic [OFFSET_W-1:0]           s1_offset;
  logic [SLOT_W-1:0]             s1_slot, rd_slot, wr_slot;
  logic [DATA_W-1:0]             rd_data, wr_data;

  mp2_scan #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SLOT_W      (SLOT_W)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .s1_go       (s1_go),
    .s1_valid_r  (s1_valid),
    .s1_flags_r  (s1_flags),
    .s1_sample_r (s1_sample),
    .s1_offset_r (s1_offset),
    .s1_slot_r   (s1_slot),
    .rd_en       (rd_en),
    .rd_slot     (rd_slot)
  );

  mp2_line_store #(
    .DEPTH  (LINE_DEPTH),
    .SLOT_W (SLOT_W),
    .DATA_W (DATA_W)
  ) u_line (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_slot   (rd_slot),
    .wr_en     (wr_en),
    .wr_slot   (wr_slot),
    .wr_data   (wr_data),
    .rd_data_r (rd_data)
  );

  mp2_reduce #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SLOT_W      (SLOT_W)
  ) u_reduce (
    .clk            (clk),
    .rst_n          (rst_n),
    .s1_valid       (s1_valid),
    .s1_flags       (s1_flags),
    .s1_sample      (s1_sample),
    .s1_offset      (s1_offset),
    .s1_slot        (s1_slot),
    .rd_data        (rd_data),
    .s1_go          (s1_go),
    .wr_en          (wr_en),
    .wr_slot        (wr_slot),
    .wr_data        (wr_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_max_value  (out_max_value),
    .out_max_offset (out_max_offset),
    .out_plane_last (out_plane_last)
  );

endmodule
`default_nettype wire

/* tb/sv/pool_window_checker.sv */
`timescale 1ns / 100ps
// pool_window_checker: watches the register, item and result ports of max_pool_2x2_argmax,
// predicts every pooled 2x2 window with its argmax and compares each result field
// depends on mp2_pkg
module pool_window_checker
  import mp2_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_wdata,
  input  wire logic                      in_valid,
  input  wire logic                      in_ready,
  input  wire logic signed [VALUE_W-1:0] in_sample,
  input  wire logic                      out_valid,
  input  wire logic                      out_ready,
  input  wire logic signed [VALUE_W-1:0] out_max_value,
  input  wire logic [OFFSET_W-1:0]       out_max_offset,
  input  wire logic                      out_plane_last,
  output int unsigned                    mismatch_count,
  output int unsigned                    pending_count
);

  localparam int LINE_SLOTS = MAX_WIDTH / 2;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [OFFSET_W-1:0]       offset;
    logic                      last;
  } window_result_t;

  window_result_t            expected_windows[$];
  logic signed [VALUE_W-1:0] top_pair_max [LINE_SLOTS];
  logic [OFFSET_W-1:0]       top_pair_offset [LINE_SLOTS];
  logic signed [VALUE_W-1:0] leader_value;
  logic [OFFSET_W-1:0]       leader_offset;
  logic [CFG_W-1:0]          width_reg;
  logic [CFG_W-1:0]          height_reg;
  int unsigned               col_pos;
  int unsigned               row_pos;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  task automatic take_sample(input logic signed [VALUE_W-1:0] s);
    int unsigned         w;
    int unsigned         h;
    int unsigned         slot;
    logic                odd_row;
    logic                odd_col;
    logic [OFFSET_W-1:0] here;
    window_result_t      r;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    here = OFFSET_W'(row_pos * w + col_pos);
    slot = (col_pos >> 1) % LINE_SLOTS;
    odd_row = row_pos[0];
    odd_col = col_pos[0];
    // odd last column or row falls outside every window
    if (col_pos < (w & ~32'd1) && row_pos < (h & ~32'd1)) begin
      if (!odd_row && !odd_col) begin
        leader_value = s;
        leader_offset = here;
      end else begin
        if (odd_row && !odd_col) begin
          leader_value = top_pair_max[slot];
          leader_offset = top_pair_offset[slot];
        end
        // strictly greater wins, ties keep the earlier sample
        if (s > leader_value) begin
          leader_value = s;
          leader_offset = here;
        end
        if (!odd_row && odd_col) begin
          top_pair_max[slot] = leader_value;
          top_pair_offset[slot] = leader_offset;
        end
        if (odd_row && odd_col) begin
          r.value = leader_value;
          r.offset = leader_offset;
          r.last = (row_pos == (h & ~32'd1) - 1) && (col_pos == (w & ~32'd1) - 1);
          expected_windows.push_back(r);
        end
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    window_result_t want;
    if (!rst_n) begin
      expected_windows.delete();
      col_pos = 0;
      row_pos = 0;
      leader_value = '0;
      leader_offset = '0;
      width_reg = CFG_W'(2);
      height_reg = CFG_W'(2);
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_windows.size() == 0) begin
          report_mismatch($sformatf("result with no window pending: value %0d offset %0d",
                                    out_max_value, out_max_offset));
        end else begin
          want = expected_windows.pop_front();
          if (out_max_value !== want.value)
            report_mismatch($sformatf("max_value %0d, expected %0d", out_max_value, want.value));
          if (out_max_offset !== want.offset)
            report_mismatch($sformatf("max_offset %0d, expected %0d",
                                      out_max_offset, want.offset));
          if (out_plane_last !== want.last)
            report_mismatch($sformatf("plane_last %b, expected %b", out_plane_last, want.last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PLANE_WIDTH:  width_reg = cfg_wdata;
          REG_PLANE_HEIGHT: height_reg = cfg_wdata;
          default:          ;
        endcase
        // any register write restarts the plane
        col_pos = 0;
        row_pos = 0;
      end
      if (in_valid && in_ready) take_sample(in_sample);
    end
    pending_count = expected_windows.size();
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// testbench: drives sample items and plane size writes into max_pool_2x2_argmax
// with random idling on both sides, and gives the verdict from pool_window_checker
// depends on mp2_pkg, max_pool_2x2_argmax and pool_window_checker
module testbench;
  import mp2_pkg::*;

  localparam int MAX_WIDTH   = 1024;
  localparam int SAMPLE_BITS = 16;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic                          cfg_index = REG_PLANE_WIDTH;
  logic [CFG_W-1:0]              cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [VALUE_W-1:0]     out_max_value;
  logic [OFFSET_W-1:0]           out_max_offset;
  logic                          out_plane_last;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned random_sent = 0;
  int unsigned hold_left = 0;
  logic        steady = 1'b0;
  logic        pressure_req = 1'b0;
  logic        pressure_done = 1'b0;

  // 2x2 windows in raster order: TL, TR, BL, BR
  logic signed [15:0] directed_samples [0:23] = '{
    16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
    16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
    16'sd1,    16'sd2,    16'sd3,    16'sd4,
    16'sd4,    16'sd3,    16'sd2,    16'sd1,
    16'sd0,    16'sd5,    16'sd5,    16'sd5,
    16'sd0,    16'sd0,    16'sd7,    16'sd7
  };

  always #5 clk = ~clk;

  max_pool_2x2_argmax #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_max_value (out_max_value),
    .out_max_offset(out_max_offset),
    .out_plane_last(out_plane_last)
  );

  pool_window_checker #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_max_value (out_max_value),
    .out_max_offset(out_max_offset),
    .out_plane_last(out_plane_last),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  // result side: random stalls, one long hold-off, no stalls in the steady stretch
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (pressure_req && !pressure_done) begin
      out_ready <= 1'b0;
      hold_left <= 400;
      pressure_done <= 1'b1;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 38);
    end
  end

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3:    return 16'($urandom_range(0, 4) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 11))
      0:       return CFG_W'($urandom_range(0, 1));
      1:       return CFG_W'(2047);
      2:       return CFG_W'(1024 + $urandom_range(0, 1));
      default: return CFG_W'($urandom_range(2, 9));
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input logic signed [15:0] s);
    while (!steady && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_regs(input logic do_w, input logic do_h,
                            input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    if (do_w) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_PLANE_WIDTH;
      cfg_wdata <= w;
      @(negedge clk);
    end
    if (do_h) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_PLANE_HEIGHT;
      cfg_wdata <= h;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic do_w, input logic do_h, input logic [CFG_W-1:0] w,
                           input logic [CFG_W-1:0] h, input int n, input logic with_pressure);
    int k;
    while (pending_count != 0) @(negedge clk);
    // items that make no result may still be inside the block
    repeat (4) @(negedge clk);
    write_regs(do_w, do_h, w, h);
    for (k = 0; k < n; k++) begin
      steady <= (random_sent >= 150 && random_sent < 300);
      if (with_pressure && k == 0) pressure_req <= 1'b1;
      send_item(pick_sample());
      random_sent++;
    end
    in_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int   k;
    int   drain_wait;
    logic do_w;
    logic do_h;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // reset plane size is 2x2, so every four items close a plane
    for (k = 0; k < 24; k++) send_item(directed_samples[k]);
    in_valid <= 1'b0;
    run_phase(1'b1, 1'b1, CFG_W'(4), CFG_W'(6), 48, 1'b1);
    while (random_sent < 300) begin
      do_w = $urandom_range(0, 3) != 0;
      do_h = !do_w || ($urandom_range(0, 1) == 1);
      run_phase(do_w, do_h, pick_dim(), pick_dim(), $urandom_range(10, 60), 1'b0);
    end
    // widest clamp on part of a top row, then the tallest clamp with the narrowest clamp
    run_phase(1'b1, 1'b1, CFG_W'(2047), CFG_W'(0), 40, 1'b0);
    run_phase(1'b1, 1'b1, CFG_W'(1), CFG_W'(2047), 120, 1'b0);
    drain_wait = 0;
    while (pending_count != 0 && drain_wait < 5000) begin
      @(negedge clk);
      drain_wait++;
    end
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
